>>> rtl/slfs_pkg.sv
`timescale 1ns / 1ps
// Package for the stair light fade sequencer: codes, defaults and shared types.
// No dependencies; imported by every module of the block.
package slfs_pkg;

	localparam int unsigned NUM_STEPS_DEF  = 14;
	localparam int unsigned FULL_SCALE_DEF = 4000;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned DIST_W  = 13;
	localparam int unsigned CHAN_W  = 4;
	localparam int unsigned LEVEL_W = 12;
	localparam int unsigned DELAY_W = 16;
	localparam int unsigned TICK_W  = 8;
	localparam int unsigned GAP_W   = 10;
	localparam int unsigned IDX_W   = 3;
	localparam int unsigned WDATA_W = 16;

	localparam logic [DIST_W-1:0]  THR_TOP_RST    = 13'd100;
	localparam logic [DIST_W-1:0]  THR_BOTTOM_RST = 13'd100;
	localparam logic [DELAY_W-1:0] OFF_DELAY_RST  = 16'd10000;
	localparam logic [LEVEL_W-1:0] UP_STEP_RST    = 12'd80;
	localparam logic [LEVEL_W-1:0] DOWN_STEP_RST  = 12'd30;
	localparam logic [TICK_W-1:0]  TICK_DELAY_RST = 8'd2;
	localparam logic [GAP_W-1:0]   GAP_RST        = 10'd250;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 2'd0,
		CMD_TOP    = 2'd1,
		CMD_BOTTOM = 2'd2
	} cmd_t;

	typedef enum logic [IDX_W-1:0] {
		REG_THR_TOP    = 3'd0,
		REG_THR_BOTTOM = 3'd1,
		REG_OFF_DELAY  = 3'd2,
		REG_UP_STEP    = 3'd3,
		REG_DOWN_STEP  = 3'd4,
		REG_TICK_DELAY = 3'd5,
		REG_STAIR_GAP  = 3'd6
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_UP   = 2'd1,
		MODE_LIT  = 2'd2,
		MODE_DOWN = 2'd3
	} mode_t;

	typedef struct packed {
		logic [DIST_W-1:0]  thr_top;
		logic [DIST_W-1:0]  thr_bottom;
		logic [DELAY_W-1:0] off_delay;
		logic [LEVEL_W-1:0] up_step;
		logic [LEVEL_W-1:0] down_step;
		logic [TICK_W-1:0]  tick_delay;
		logic [GAP_W-1:0]   stair_gap;
	} cfg_t;

	typedef struct packed {
		logic               valid;
		logic [CHAN_W-1:0]  channel;
		logic [LEVEL_W-1:0] level;
		logic               lights_on;
	} res_t;

endpackage

>>> rtl/slfs_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file of the stair light fade sequencer.
// Depends on slfs_pkg for register indexes, widths and reset values.
module slfs_cfg_regs
	import slfs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [WDATA_W-1:0] cfg_wdata,
	output cfg_t               cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.thr_top    <= THR_TOP_RST;
			cfg_q.thr_bottom <= THR_BOTTOM_RST;
			cfg_q.off_delay  <= OFF_DELAY_RST;
			cfg_q.up_step    <= UP_STEP_RST;
			cfg_q.down_step  <= DOWN_STEP_RST;
			cfg_q.tick_delay <= TICK_DELAY_RST;
			cfg_q.stair_gap  <= GAP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_THR_TOP:    cfg_q.thr_top    <= cfg_wdata[DIST_W-1:0];
				REG_THR_BOTTOM: cfg_q.thr_bottom <= cfg_wdata[DIST_W-1:0];
				REG_OFF_DELAY:  cfg_q.off_delay  <= cfg_wdata[DELAY_W-1:0];
				REG_UP_STEP:    cfg_q.up_step    <= cfg_wdata[LEVEL_W-1:0];
				REG_DOWN_STEP:  cfg_q.down_step  <= cfg_wdata[LEVEL_W-1:0];
				REG_TICK_DELAY: cfg_q.tick_delay <= cfg_wdata[TICK_W-1:0];
				REG_STAIR_GAP:  cfg_q.stair_gap  <= cfg_wdata[GAP_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> rtl/slfs_core.sv
`timescale 1ns / 1ps
// Sequencer state and single-pass update logic: trigger, ramp, gaps, timer.
// Depends on slfs_pkg for codes, the config struct and the result struct.
module slfs_core
	import slfs_pkg::*;
#(
	parameter int unsigned NUM_STEPS  = NUM_STEPS_DEF,
	parameter int unsigned FULL_SCALE = FULL_SCALE_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              proc_en,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [DIST_W-1:0] dist_mm,
	input  cfg_t              cfg,
	output res_t              res
);

	localparam logic [LEVEL_W-1:0] FS       = LEVEL_W'(FULL_SCALE);
	localparam logic [CHAN_W:0]    STEPS    = (CHAN_W + 1)'(NUM_STEPS);
	localparam logic [CHAN_W-1:0]  LAST_CH  = CHAN_W'(NUM_STEPS - 1);

	mode_t              mode_q, mode_n, e_mode;
	logic               asc_q, asc_n;
	logic [CHAN_W-1:0]  step_q, step_n, e_step;
	logic [LEVEL_W-1:0] ramp_q, ramp_n, e_ramp;
	logic [GAP_W-1:0]   wait_q, wait_n;
	logic [DELAY_W-1:0] since_q, since_n, since_inc;
	logic               emit;
	logic [DIST_W-1:0]  thr;
	logic [LEVEL_W-1:0] stp;
	logic [LEVEL_W:0]   ramp_sum;

	always_comb begin
		since_inc = (since_q == '1) ? since_q : since_q + 1'b1;
		thr       = (cmd == CMD_TOP) ? cfg.thr_top : cfg.thr_bottom;
	end

	always_comb begin
		mode_n  = mode_q;
		asc_n   = asc_q;
		step_n  = step_q;
		ramp_n  = ramp_q;
		wait_n  = wait_q;
		since_n = since_q;
		e_mode  = mode_q;
		e_step  = step_q;
		e_ramp  = ramp_q;
		emit    = 1'b0;
		if (proc_en) begin
			case (cmd)
				CMD_TOP, CMD_BOTTOM: begin
					if (mode_q == MODE_IDLE && dist_mm < thr) begin
						asc_n   = (cmd == CMD_BOTTOM);
						since_n = '0;
						e_mode  = MODE_UP;
						e_step  = '0;
						e_ramp  = '0;
						emit    = 1'b1;
					end
				end
				CMD_TICK: begin
					since_n = since_inc;
					case (mode_q)
						MODE_LIT: begin
							if (since_inc > cfg.off_delay) begin
								e_mode = MODE_DOWN;
								e_step = '0;
								e_ramp = '0;
								emit   = 1'b1;
							end
						end
						MODE_UP, MODE_DOWN: begin
							if (wait_q > GAP_W'(1)) begin
								wait_n = wait_q - 1'b1;
							end else if (ramp_q >= FS) begin
								ramp_n = '0;
								if ({1'b0, step_q} + 1'b1 >= STEPS) begin
									step_n = '0;
									wait_n = '0;
									mode_n = (mode_q == MODE_UP) ? MODE_LIT : MODE_IDLE;
								end else begin
									step_n = step_q + 1'b1;
									wait_n = cfg.stair_gap;
								end
							end else begin
								emit = 1'b1;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
		stp      = (e_mode == MODE_UP) ? cfg.up_step : cfg.down_step;
		stp      = (stp == '0) ? LEVEL_W'(1) : stp;
		ramp_sum = {1'b0, e_ramp} + {1'b0, stp};
		if (emit) begin
			mode_n = e_mode;
			step_n = e_step;
			ramp_n = (ramp_sum >= {1'b0, FS}) ? FS : ramp_sum[LEVEL_W-1:0];
			wait_n = GAP_W'(cfg.tick_delay);
		end
	end

	always_comb begin
		res.valid     = emit;
		res.channel   = asc_n ? e_step : LAST_CH - e_step;
		res.level     = (e_mode == MODE_UP) ? e_ramp : FS - e_ramp;
		res.lights_on = (e_mode != MODE_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			asc_q   <= 1'b0;
			step_q  <= '0;
			ramp_q  <= '0;
			wait_q  <= '0;
			since_q <= '0;
		end else begin
			mode_q  <= mode_n;
			asc_q   <= asc_n;
			step_q  <= step_n;
			ramp_q  <= ramp_n;
			wait_q  <= wait_n;
			since_q <= since_n;
		end
	end

	a_ramp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ramp_q <= FS)
		else $error("ramp position beyond full scale");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, step_q} < STEPS)
		else $error("step index beyond channel count");
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == MODE_IDLE |-> ramp_q == '0 && step_q == '0)
		else $error("idle with stale ramp state");
	a_emit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> mode_q == MODE_UP || mode_q == MODE_DOWN)
		else $error("write issued outside a fade");

endmodule

>>> rtl/stair_light_fade_sequencer_unit.sv
`timescale 1ns / 1ps
// Top level of the stair light fade sequencer: input stage, result register.
// Depends on slfs_pkg, slfs_cfg_regs and slfs_core.
//
//  port group   direction  handshake            beat contents
//  item         in         item_valid/stall     command, distance_mm
//  res          out        res_valid/stall      channel, level, lights_on
//  cfg          in         cfg_we               cfg_index, cfg_wdata
//
// One beat accepted per cycle while item_stall is low; its result, if any,
// is offered from the result register. The sequencer state updates in one pass
// between the input stage and the result register. Reset clears the
// sequencer to idle and loads default configuration. res_stall holds the
// result register; item_stall rises only while the input stage holds a
// beat that cannot move.
module stair_light_fade_sequencer_unit
	import slfs_pkg::*;
#(
	parameter int unsigned NUM_STEPS  = NUM_STEPS_DEF,
	parameter int unsigned FULL_SCALE = FULL_SCALE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [CMD_W-1:0]   command,
	input  logic [DIST_W-1:0]  distance_mm,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [CHAN_W-1:0]  channel,
	output logic [LEVEL_W-1:0] level,
	output logic               lights_on,
	input  logic               cfg_we,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [WDATA_W-1:0] cfg_wdata
);

	logic               valid_s1;
	logic [CMD_W-1:0]   cmd_s1;
	logic [DIST_W-1:0]  dist_s1;
	logic               proc_en;
	logic               res_open;
	cfg_t               cfg;
	res_t               res;
	logic               res_valid_q;
	logic [CHAN_W-1:0]  channel_q;
	logic [LEVEL_W-1:0] level_q;
	logic               lights_on_q;

	slfs_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	slfs_core #(
		.NUM_STEPS  (NUM_STEPS),
		.FULL_SCALE (FULL_SCALE)
	) u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.proc_en (proc_en),
		.cmd     (cmd_s1),
		.dist_mm (dist_s1),
		.cfg     (cfg),
		.res     (res)
	);

	assign res_open   = !res_valid_q || !res_stall;
	assign proc_en    = valid_s1 && res_open;
	assign item_stall = valid_s1 && !res_open;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && !item_stall) begin
			valid_s1 <= 1'b1;
		end else if (proc_en) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			cmd_s1  <= command;
			dist_s1 <= distance_mm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_open) begin
			res_valid_q <= proc_en && res.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (proc_en && res.valid) begin
			channel_q   <= res.channel;
			level_q     <= res.level;
			lights_on_q <= res.lights_on;
		end
	end

	assign res_valid = res_valid_q;
	assign channel   = channel_q;
	assign level     = level_q;
	assign lights_on = lights_on_q;

	a_stall_held: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> valid_s1 && res_valid_q)
		else $error("input stalled with a free path");

endmodule

>>> dv/tb_stair_light_fade_sequencer_unit.sv
`timescale 1ns / 1ps
// Self-checking bench for stair_light_fade_sequencer_unit: a scoreboard class tracks the
// fade sequence and checks each PWM write beat, while plain tasks drive beats and registers.
// Depends on slfs_pkg and the RTL of the block.
module tb_stair_light_fade_sequencer_unit;
	import slfs_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [IDX_W-1:0] REG_NONE   = 3'd7;
	localparam int unsigned LONG_HOLD   = 64;
	localparam int unsigned BEAT_TARGET = 1050;

	typedef struct {
		logic [CHAN_W-1:0]  channel;
		logic [LEVEL_W-1:0] level;
		logic               lights_on;
	} pwm_write_t;

	class pwm_write_board;
		logic [DIST_W-1:0]  thr_top, thr_bottom;
		logic [DELAY_W-1:0] off_delay;
		logic [LEVEL_W-1:0] up_step, down_step;
		logic [TICK_W-1:0]  tick_delay;
		logic [GAP_W-1:0]   stair_gap;
		mode_t              mode;
		bit                 ascending;
		int unsigned        stair, ramp, hold_ticks, since_trigger;
		pwm_write_t         writes_due[$];
		int unsigned        errors;

		function new();
			thr_top       = THR_TOP_RST;
			thr_bottom    = THR_BOTTOM_RST;
			off_delay     = OFF_DELAY_RST;
			up_step       = UP_STEP_RST;
			down_step     = DOWN_STEP_RST;
			tick_delay    = TICK_DELAY_RST;
			stair_gap     = GAP_RST;
			mode          = MODE_IDLE;
			ascending     = 1'b0;
			stair         = 0;
			ramp          = 0;
			hold_ticks    = 0;
			since_trigger = 0;
			errors        = 0;
		endfunction

		function int unsigned pending();
			return writes_due.size();
		endfunction

		function void set_reg(logic [IDX_W-1:0] idx, logic [WDATA_W-1:0] val);
			case (idx)
			REG_THR_TOP:    thr_top    = val[DIST_W-1:0];
			REG_THR_BOTTOM: thr_bottom = val[DIST_W-1:0];
			REG_OFF_DELAY:  off_delay  = val[DELAY_W-1:0];
			REG_UP_STEP:    up_step    = val[LEVEL_W-1:0];
			REG_DOWN_STEP:  down_step  = val[LEVEL_W-1:0];
			REG_TICK_DELAY: tick_delay = val[TICK_W-1:0];
			REG_STAIR_GAP:  stair_gap  = val[GAP_W-1:0];
			default: ;
			endcase
		endfunction

		function void push_write();
			pwm_write_t w;
			int unsigned lvl, stp;
			w.channel = CHAN_W'(ascending ? stair : NUM_STEPS_DEF - 1 - stair);
			if (mode == MODE_UP) begin
				lvl = ramp;
				stp = up_step;
			end else begin
				lvl = FULL_SCALE_DEF - ramp;
				stp = down_step;
			end
			if (stp == 0)
				stp = 1;
			w.level     = LEVEL_W'(lvl);
			w.lights_on = 1'b1;
			writes_due.push_back(w);
			ramp       = (ramp + stp >= FULL_SCALE_DEF) ? FULL_SCALE_DEF : ramp + stp;
			hold_ticks = tick_delay;
		endfunction

		function void start_fade(mode_t m);
			mode  = m;
			stair = 0;
			ramp  = 0;
			push_write();
		endfunction

		// Advance on one accepted beat; return 1 unless the beat was ignored.
		function bit take_beat(logic [CMD_W-1:0] cmd, logic [DIST_W-1:0] range_mm);
			logic [DIST_W-1:0] thr;
			if (cmd == CMD_TOP || cmd == CMD_BOTTOM) begin
				thr = (cmd == CMD_TOP) ? thr_top : thr_bottom;
				if (mode != MODE_IDLE || range_mm >= thr)
					return 1'b0;
				ascending     = (cmd == CMD_BOTTOM);
				since_trigger = 0;
				start_fade(MODE_UP);
				return 1'b1;
			end
			if (cmd != CMD_TICK)
				return 1'b0;
			if (since_trigger < 16'hFFFF)
				since_trigger++;
			if (mode == MODE_IDLE)
				return 1'b1;
			if (mode == MODE_LIT) begin
				if (since_trigger > off_delay)
					start_fade(MODE_DOWN);
				return 1'b1;
			end
			if (hold_ticks > 1) begin
				hold_ticks--;
				return 1'b1;
			end
			if (ramp >= FULL_SCALE_DEF) begin
				ramp = 0;
				if (stair + 1 >= NUM_STEPS_DEF) begin
					stair      = 0;
					hold_ticks = 0;
					if (mode == MODE_UP)
						mode = MODE_LIT;
					else
						mode = MODE_IDLE;
				end else begin
					stair++;
					hold_ticks = stair_gap;
				end
				return 1'b1;
			end
			push_write();
			return 1'b1;
		endfunction

		function void match_write(logic [CHAN_W-1:0] ch, logic [LEVEL_W-1:0] lvl, logic lit);
			pwm_write_t w;
			if (writes_due.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("write with none due: channel %0d level %0d lights_on %0b",
						ch, lvl, lit);
				return;
			end
			w = writes_due.pop_front();
			if (ch !== w.channel || lvl !== w.level || lit !== w.lights_on) begin
				errors++;
				if (errors <= 10)
					$display("write mismatch: expected channel %0d level %0d lights_on %0b, %s",
						w.channel, w.level, w.lights_on,
						$sformatf("got channel %0d level %0d lights_on %0b", ch, lvl, lit));
			end
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_stall;
	logic [CMD_W-1:0]   command = CMD_TICK;
	logic [DIST_W-1:0]  distance_mm = '0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [CHAN_W-1:0]  channel;
	logic [LEVEL_W-1:0] level;
	logic               lights_on;
	logic               cfg_we = 1'b0;
	logic [IDX_W-1:0]   cfg_index = '0;
	logic [WDATA_W-1:0] cfg_wdata = '0;

	pwm_write_board board;
	int unsigned    live_beats = 0;
	bit             calm = 1'b0;
	bit             long_hold_req = 1'b0;

	stair_light_fade_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.command(command),
		.distance_mm(distance_mm),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.channel(channel),
		.level(level),
		.lights_on(lights_on),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [DIST_W-1:0] range_mm);
		int unsigned gap;
		gap = calm ? 0 : $urandom_range(9);
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid  <= 1'b1;
		command     <= cmd;
		distance_mm <= range_mm;
		do @(posedge clk); while (item_stall);
		void'(board.take_beat(cmd, range_mm));
		live_beats++;
	endtask

	// Drop valid, drain every due write, then let the pipeline empty.
	task automatic settle();
		item_valid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_regs(input logic [WDATA_W-1:0] vals [7]);
		for (int i = REG_THR_TOP; i <= REG_STAIR_GAP; i++) begin
			cfg_we    <= 1'b1;
			cfg_index <= IDX_W'(i);
			cfg_wdata <= vals[i];
			@(posedge clk);
			board.set_reg(IDX_W'(i), vals[i]);
		end
		cfg_we    <= 1'b1;
		cfg_index <= REG_NONE;
		cfg_wdata <= WDATA_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic int unsigned draw_step();
		if ($urandom_range(3) == 0)
			return $urandom_range(50, 599);
		return $urandom_range(600, 4095);
	endfunction

	function automatic void draw_config(output logic [WDATA_W-1:0] vals [7]);
		vals[REG_THR_TOP]    = ($urandom_range(9) == 0) ? '0 : WDATA_W'($urandom_range(8191));
		vals[REG_THR_BOTTOM] = ($urandom_range(9) == 0) ? '0 : WDATA_W'($urandom_range(8191));
		case ($urandom_range(9))
		0:       vals[REG_OFF_DELAY] = 16'hFFFF;
		1:       vals[REG_OFF_DELAY] = WDATA_W'($urandom);
		2:       vals[REG_OFF_DELAY] = '0;
		default: vals[REG_OFF_DELAY] = WDATA_W'($urandom_range(1, 120));
		endcase
		vals[REG_UP_STEP]    = WDATA_W'(draw_step());
		vals[REG_DOWN_STEP]  = WDATA_W'(draw_step());
		vals[REG_TICK_DELAY] = WDATA_W'(($urandom_range(9) == 0) ? $urandom_range(3, 12)
			: $urandom_range(0, 2));
		vals[REG_STAIR_GAP]  = WDATA_W'($urandom_range(0, 6));
	endfunction

	function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] thr);
		case ($urandom_range(5))
		0:       return DIST_W'($urandom_range(8191));
		1:       return thr;
		2:       return (thr == 0) ? '0 : thr - 1'b1;
		3:       return '0;
		4:       return '1;
		default: return (thr == 0) ? '0 : DIST_W'($urandom_range(thr - 1));
		endcase
	endfunction

	// Mostly ticks; trigger often while dark, with stray samples and unused commands.
	task automatic run_phase(input int unsigned beats);
		int unsigned goal, r;
		logic [CMD_W-1:0] side;
		goal = live_beats + beats;
		while (live_beats < goal) begin
			r    = $urandom_range(99);
			side = $urandom_range(1) ? CMD_TOP : CMD_BOTTOM;
			if ((board.mode == MODE_IDLE && r < 40) || (r >= 86 && r < 95))
				send_beat(side, pick_distance((side == CMD_TOP) ? board.thr_top
					: board.thr_bottom));
			else if (r >= 95)
				send_beat(CMD_UNUSED, DIST_W'($urandom));
			else
				send_beat(CMD_TICK, DIST_W'($urandom));
		end
	endtask

	initial begin : result_sink
		int unsigned hold;
		hold = 0;
		forever begin
			@(posedge clk);
			if (res_valid === 1'b1 && res_stall === 1'b0) begin
				board.match_write(channel, level, lights_on);
				hold = calm ? 0 : $urandom_range(9);
			end
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				hold          = LONG_HOLD;
			end
			if (hold != 0) begin
				res_stall <= 1'b1;
				hold--;
			end else
				res_stall <= 1'b0;
		end
	end

	initial begin : stimulus
		logic [WDATA_W-1:0] regs [7];
		int unsigned phase_no;
		board    = new();
		phase_no = 0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults: strict thresholds, ignored samples while fading, tick pacing.
		send_beat(CMD_UNUSED, '1);
		send_beat(CMD_TICK, '0);
		send_beat(CMD_TOP, 13'd100);
		send_beat(CMD_BOTTOM, 13'd100);
		send_beat(CMD_TOP, '1);
		send_beat(CMD_TOP, 13'd99);
		send_beat(CMD_BOTTOM, '0);
		send_beat(CMD_TOP, '0);
		repeat (3) send_beat(CMD_TICK, '1);
		send_beat(CMD_UNUSED, '0);
		repeat (4) send_beat(CMD_TICK, '0);

		// Write every tick, then hold the sink off so the block backs up.
		settle();
		regs = '{WDATA_W'(THR_TOP_RST), WDATA_W'(THR_BOTTOM_RST), 16'd0, 16'd400, 16'd400,
			16'd0, 16'd0};
		write_regs(regs);
		calm = 1'b1;
		repeat (6) send_beat(CMD_TICK, '0);
		long_hold_req = 1'b1;
		repeat (60) send_beat(CMD_TICK, DIST_W'($urandom));
		settle();
		repeat (40) send_beat(CMD_TICK, DIST_W'($urandom));

		while (live_beats < BEAT_TARGET - 40) begin
			settle();
			if (phase_no == 6)
				regs = '{default: '0};
			else
				draw_config(regs);
			write_regs(regs);
			calm = ($urandom_range(3) == 0);
			run_phase($urandom_range(40, 80));
			phase_no++;
		end

		settle();
		regs = '{16'h1FFF, 16'h1FFF, 16'hFFFF, 16'h0FFF, 16'h0FFF, 16'h00FF, 16'h03FF};
		write_regs(regs);
		calm = 1'b0;
		run_phase(40);

		settle();
		if (board.errors == 0 && board.pending() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#4_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
